FILE: src/byte_driven_permutation_shuffle_defines.svh
// assertion macros shared by the shuffle checker
`ifndef BYTE_DRIVEN_PERMUTATION_SHUFFLE_DEFINES_SVH
`define BYTE_DRIVEN_PERMUTATION_SHUFFLE_DEFINES_SVH

// property checked on every clock edge outside reset
`define BDPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define BDPS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/bdps_pkg.sv
// shared types, constants and microprogram of the permutation shuffle
`default_nettype none

package bdps_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int SAMPLE_W       = 8;
  localparam int BYTE_RANGE     = 2 ** SAMPLE_W;
  // remaining slot count reaches the full byte range
  localparam int DIV_W          = SAMPLE_W + 1;
  localparam int STEP_W         = 4;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    MODE_RESTART = 2'd0,
    MODE_ENTROPY = 2'd1,
    MODE_READ    = 2'd2
  } mode_t;

  // jump conditions of the microprogram
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_MODE_RST,
    C_NOT_ENT,
    C_FINISHED,
    C_DIV_BUSY,
    C_REJECT,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_POS,
    RD_OTHER,
    RD_IDX
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_POS,
    WR_OTHER
  } wr_sel_t;

  // one control word per program step
  typedef struct packed {
    cond_t   cond;
    step_t   target;
    logic    last;
    logic    take_in;
    logic    restart;
    logic    div_start;
    rd_sel_t rd_sel;
    logic    hold_a;
    wr_sel_t wr_sel;
    logic    advance;
    logic    emit;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic no_in;
    logic mode_rst;
    logic not_ent;
    logic finished;
    logic div_busy;
    logic reject;
    logic out_busy;
  } stat_t;

  // program step addresses
  localparam step_t S_WAIT   = 4'd0;
  localparam step_t S_DISP   = 4'd1;
  localparam step_t S_KIND   = 4'd2;
  localparam step_t S_START  = 4'd3;
  localparam step_t S_DIV    = 4'd4;
  localparam step_t S_CHECK  = 4'd5;
  localparam step_t S_GETA   = 4'd6;
  localparam step_t S_PUTB   = 4'd7;
  localparam step_t S_PUTA   = 4'd8;
  localparam step_t S_RST    = 4'd9;
  localparam step_t S_READ   = 4'd10;
  localparam step_t S_RESULT = 4'd11;

  // microprogram rom
  function automatic ctrl_t prog_word(input step_t step);
    ctrl_t w;
    w = '0;
    case (step)
      S_WAIT: begin
        w.take_in = 1'b1;
        w.cond    = C_NO_IN;
        w.target  = S_WAIT;
      end
      S_DISP: begin
        w.cond   = C_MODE_RST;
        w.target = S_RST;
      end
      S_KIND: begin
        w.cond   = C_NOT_ENT;
        w.target = S_READ;
      end
      S_START: begin
        w.div_start = 1'b1;
        w.cond      = C_FINISHED;
        w.target    = S_RESULT;
      end
      S_DIV: begin
        w.cond   = C_DIV_BUSY;
        w.target = S_DIV;
      end
      S_CHECK: begin
        w.rd_sel = RD_POS;
        w.cond   = C_REJECT;
        w.target = S_RESULT;
      end
      S_GETA: begin
        w.hold_a = 1'b1;
        w.rd_sel = RD_OTHER;
      end
      S_PUTB: begin
        w.wr_sel = WR_POS;
      end
      S_PUTA: begin
        w.wr_sel  = WR_OTHER;
        w.advance = 1'b1;
        w.cond    = C_ALWAYS;
        w.target  = S_RESULT;
      end
      S_RST: begin
        w.restart = 1'b1;
        w.cond    = C_ALWAYS;
        w.target  = S_RESULT;
      end
      S_READ: begin
        w.rd_sel = RD_IDX;
      end
      S_RESULT: begin
        w.emit   = 1'b1;
        w.cond   = C_OUT_BUSY;
        w.target = S_RESULT;
        w.last   = 1'b1;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: src/bdps_seq.sv
// step counter and jump logic driven by the microprogram rom
`default_nettype none

module bdps_seq
  import bdps_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  step_t step_r, step_nxt;
  logic  jump;

  assign ctrl = prog_word(step_r);

  // condition select and next step
  always_comb begin
    case (ctrl.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_IN:    jump = stat.no_in;
      C_MODE_RST: jump = stat.mode_rst;
      C_NOT_ENT:  jump = stat.not_ent;
      C_FINISHED: jump = stat.finished;
      C_DIV_BUSY: jump = stat.div_busy;
      C_REJECT:   jump = stat.reject;
      C_OUT_BUSY: jump = stat.out_busy;
      default:    jump = 1'b0;
    endcase
    if (jump) begin
      step_nxt = ctrl.target;
    end else if (ctrl.last) begin
      step_nxt = S_WAIT;
    end else begin
      step_nxt = step_t'(step_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/bdps_mod.sv
// bit-serial remainder unit, one dividend bit per cycle
`default_nettype none

module bdps_mod
  import bdps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] dividend,
  input  logic [DIV_W-1:0]    divisor,
  output logic                busy,
  output logic [SAMPLE_W-1:0] rem
);

  localparam int CNT_W = $clog2(SAMPLE_W + 1);

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0]    part_r, part_nxt;
  logic [DIV_W-1:0]    dsr_r, dsr_nxt;
  logic [DIV_W-1:0]    trial;

  assign busy = (cnt_r != '0);
  // partial remainder stays below the divisor, so it fits a byte
  assign rem  = part_r[SAMPLE_W-1:0];

  // restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {part_r[SAMPLE_W-1:0], dvd_r[SAMPLE_W-1]};
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    part_nxt = part_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      cnt_nxt  = CNT_W'(SAMPLE_W);
      dvd_nxt  = dividend;
      part_nxt = '0;
      dsr_nxt  = divisor;
    end else if (busy) begin
      cnt_nxt  = cnt_r - 1'b1;
      dvd_nxt  = {dvd_r[SAMPLE_W-2:0], 1'b0};
      part_nxt = (trial >= dsr_r) ? (trial - dsr_r) : trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    part_r <= part_nxt;
    dsr_r  <= dsr_nxt;
  end

endmodule

`default_nettype wire

FILE: src/bdps_table.sv
// permutation table memory with per-entry valid bits for identity reset
`default_nettype none

module bdps_table
  import bdps_pkg::*;
#(
  parameter int DEPTH = TABLE_SIZE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] wr_data
);

  logic [AW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [AW-1:0]    rd_word_r;
  logic [AW-1:0]    rd_addr_r;
  logic             rd_hit_r;

  // valid bits: cleared entries read back as their own index
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
      rd_hit_r  <= vld_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  assign rd_data = rd_hit_r ? rd_word_r : rd_addr_r;

endmodule

`default_nettype wire

FILE: src/byte_driven_permutation_shuffle.sv
// Byte-driven permutation shuffle: forward shuffle of a TABLE_SIZE-entry
// table driven by entropy bytes, with rejection of biased bytes.
// Input channel (in_valid/in_ready) takes one item: mode 0 restarts the
// table as identity, mode 1 offers an entropy byte, mode 2 reads the entry
// at in_read_index. Every item gives exactly one beat on the output
// channel (out_valid/out_ready) carrying the entry read, the count of
// placed slots, the done flag and whether the byte caused a swap.
// One item is handled at a time by a microcoded sequencer: a restart or
// read goes through its own step, a byte after done straight to the
// result, a rejected byte through the remainder unit and the check, and a
// used byte on through the three-step swap through the table. The next
// item is taken once the result step is left. The remainder unit is
// bit-serial, one dividend bit per cycle.
// Reset clears the step counter and position and marks every table entry
// as identity at once; the block is ready for an item once reset ends.
// A result waits in the output register while the receiver stalls; the
// sequencer may meanwhile take and work on the next item, but holds at
// the result step, taking nothing new, until the waiting beat has left.
`default_nettype none

module byte_driven_permutation_shuffle
  import bdps_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [SAMPLE_W-1:0] in_entropy_byte,
  input  logic [SAMPLE_W-1:0] in_read_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_entry_value,
  output logic [SAMPLE_W-1:0] out_placed_count,
  output logic                out_shuffle_done,
  output logic                out_byte_used
);

  localparam int AW = $clog2(TABLE_SIZE);

  ctrl_t               ctrl;
  stat_t               stat;
  logic                in_fire;
  logic                out_load;

  logic [1:0]          mode_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] idx_r;
  logic [AW-1:0]       hold_r;

  logic [AW-1:0]       pos_r, pos_nxt;
  logic                fin_r, fin_nxt;
  logic                used_r, used_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_value_r, out_count_r;
  logic                out_done_r, out_used_r;
  logic [SAMPLE_W-1:0] entry_value;

  logic                div_busy;
  logic [SAMPLE_W-1:0] mod_rem;
  logic [DIV_W-1:0]    remaining;
  logic [DIV_W:0]      bound;
  logic [DIV_W-1:0]    other_sum;
  logic [AW-1:0]       other;
  logic                idx_ok;

  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr, wr_data, rd_data;

  // sequencer
  bdps_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // remainder of the byte by the remaining slot count
  bdps_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (sample_r),
    .divisor  (remaining),
    .busy     (div_busy),
    .rem      (mod_rem)
  );

  // permutation table
  bdps_table #(
    .DEPTH (TABLE_SIZE),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (ctrl.restart),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ready = ctrl.take_in;
  assign in_fire  = in_valid && in_ready;

  // slot arithmetic
  assign remaining = DIV_W'(TABLE_SIZE) - DIV_W'(pos_r);
  assign other_sum = DIV_W'(pos_r) + DIV_W'(mod_rem);
  assign other     = other_sum[AW-1:0];
  assign idx_ok    = DIV_W'(idx_r) < DIV_W'(TABLE_SIZE);

  // reject when the byte falls in the last, incomplete block of remaining:
  // byte - rem + remaining exceeds the byte range
  assign bound = (DIV_W+1)'(sample_r) - (DIV_W+1)'(mod_rem) + (DIV_W+1)'(remaining);

  // status to the sequencer
  always_comb begin
    stat.no_in    = !in_valid;
    stat.mode_rst = (mode_r == MODE_RESTART);
    stat.not_ent  = (mode_r != MODE_ENTROPY);
    stat.finished = fin_r;
    stat.div_busy = div_busy;
    stat.reject   = (bound > (DIV_W+1)'(BYTE_RANGE));
    stat.out_busy = out_valid_r && !out_ready;
  end

  // table port selection
  assign rd_en = (ctrl.rd_sel != RD_NONE);
  assign wr_en = (ctrl.wr_sel != WR_NONE);

  always_comb begin
    case (ctrl.rd_sel)
      RD_POS:   rd_addr = pos_r;
      RD_OTHER: rd_addr = other;
      RD_IDX:   rd_addr = idx_r[AW-1:0];
      default:  rd_addr = pos_r;
    endcase
  end

  always_comb begin
    case (ctrl.wr_sel)
      WR_POS: begin
        wr_addr = pos_r;
        wr_data = rd_data;
      end
      WR_OTHER: begin
        wr_addr = other;
        wr_data = hold_r;
      end
      default: begin
        wr_addr = pos_r;
        wr_data = rd_data;
      end
    endcase
  end

  // shuffle state
  always_comb begin
    pos_nxt  = pos_r;
    fin_nxt  = fin_r;
    used_nxt = used_r;
    if (in_fire) begin
      used_nxt = 1'b0;
    end
    if (ctrl.restart) begin
      pos_nxt = '0;
      // a fresh table is never done; the table size is assumed to be at least two
      fin_nxt = 1'b0;
    end else if (ctrl.advance) begin
      pos_nxt  = pos_r + 1'b1;
      fin_nxt  = (pos_r == AW'(TABLE_SIZE - 2));
      used_nxt = 1'b1;
    end
  end

  // output register
  assign out_load      = ctrl.emit && !stat.out_busy;
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign entry_value   = ((mode_r == MODE_READ) && idx_ok) ? SAMPLE_W'(rd_data) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      fin_r       <= 1'b0;
      used_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      fin_r       <= fin_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r   <= in_mode;
      sample_r <= in_entropy_byte;
      idx_r    <= in_read_index;
    end
    if (ctrl.hold_a) begin
      hold_r <= rd_data;
    end
    if (out_load) begin
      out_value_r <= entry_value;
      out_count_r <= SAMPLE_W'(pos_r);
      out_done_r  <= fin_r;
      out_used_r  <= used_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_entry_value  = out_value_r;
  assign out_placed_count = out_count_r;
  assign out_shuffle_done = out_done_r;
  assign out_byte_used    = out_used_r;

endmodule

`default_nettype wire

FILE: src/bdps_checker.sv
// port-level checker for the permutation shuffle, bound to the top level
`default_nettype none
`include "byte_driven_permutation_shuffle_defines.svh"

module bdps_checker
  import bdps_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_entry_value,
  input logic [SAMPLE_W-1:0] out_placed_count,
  input logic                out_shuffle_done,
  input logic                out_byte_used
);

  logic                    stall;
  logic [2*SAMPLE_W+1:0]   out_beat;
  logic                    last_slot;
  logic                    swap_beat;

  assign stall     = out_valid && !out_ready;
  assign out_beat  = {out_entry_value, out_placed_count, out_shuffle_done, out_byte_used};
  assign last_slot = (out_placed_count == SAMPLE_W'(TABLE_SIZE - 1));
  assign swap_beat = out_valid && out_byte_used;

  // a stalled result beat holds
  `BDPS_ASSERT(a_out_hold, stall |=> out_valid && $stable(out_beat), "stalled beat changed")

  // done flag tracks the last placed slot
  `BDPS_ASSERT(a_done_count, out_valid |-> out_shuffle_done == last_slot, "done flag wrong")

  // a swap beat never carries a table entry
  `BDPS_ASSERT(a_used_no_entry, swap_beat |-> out_entry_value == '0, "entry value on a swap beat")

  // reset empties the output and opens the input
  `BDPS_ASSERT_RST(a_reset_state, !rst_n |=> !out_valid && in_ready, "bad state after reset")

endmodule

bind byte_driven_permutation_shuffle bdps_checker #(.TABLE_SIZE(TABLE_SIZE)) u_bdps_checker (.*);

`default_nettype wire

FILE: tb/tb_byte_driven_permutation_shuffle.sv
// self-checking testbench for the byte-driven permutation shuffle
`timescale 1ns / 100ps

module tb_byte_driven_permutation_shuffle;
  import bdps_pkg::*;

  // the one mode value the package leaves unnamed
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         SLOTS       = 256;
  localparam int         ITEM_GOAL   = 1030;
  localparam int         FULL_BYTES  = 330;
  localparam int         DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] entropy;
    logic [7:0] index;
  } shuffle_item_t;

  typedef struct packed {
    logic [7:0] entry_value;
    logic [7:0] placed_count;
    logic       shuffle_done;
    logic       byte_used;
  } shuffle_status_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_mode = MODE_RESTART;
  logic [7:0] in_entropy_byte = '0;
  logic [7:0] in_read_index = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_entry_value;
  logic [7:0] out_placed_count;
  logic       out_shuffle_done;
  logic       out_byte_used;

  // items still to send and statuses still to arrive
  shuffle_item_t   shuffle_items[$];
  shuffle_status_t predicted_status_q[$];

  // shadow copy of the table and shuffle progress
  logic [7:0] shadow_perm [SLOTS];
  logic [8:0] shadow_pos;
  logic       shadow_done;

  logic in_accept = 1'b0;
  int   accepted_items = 0;
  int   total_items = 0;
  int   mismatches = 0;
  int   send_idle_pct;
  int   recv_idle_pct;

  byte_driven_permutation_shuffle u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_entropy_byte  (in_entropy_byte),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_entry_value  (out_entry_value),
    .out_placed_count (out_placed_count),
    .out_shuffle_done (out_shuffle_done),
    .out_byte_used    (out_byte_used)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idle rates by phase: slow receiver, then slow sender, then full speed
  always_comb begin
    if (accepted_items < total_items / 3) begin
      send_idle_pct = 17;
      recv_idle_pct = 67;
    end else if (accepted_items < (2 * total_items) / 3) begin
      send_idle_pct = 67;
      recv_idle_pct = 17;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // restart the shadow table as identity
  function automatic void restart_shadow();
    for (int i = 0; i < SLOTS; i++) shadow_perm[i] = i[7:0];
    shadow_pos  = '0;
    shadow_done = 1'b0;
  endfunction

  // one item applied to the shadow table, giving the status it returns
  function automatic shuffle_status_t apply_shuffle_item(input shuffle_item_t it);
    shuffle_status_t res;
    logic [8:0]      remaining;
    logic [8:0]      limit;
    logic [8:0]      other;
    logic [7:0]      hold;
    res = '0;
    case (it.mode)
      MODE_RESTART: begin
        restart_shadow();
      end
      MODE_ENTROPY: begin
        if (!shadow_done) begin
          remaining = 9'd256 - shadow_pos;
          limit     = 9'd256 - (9'd256 % remaining);
          // biased bytes at or above the limit are dropped
          if ({1'b0, it.entropy} < limit) begin
            other = shadow_pos + ({1'b0, it.entropy} % remaining);
            hold  = shadow_perm[shadow_pos[7:0]];
            shadow_perm[shadow_pos[7:0]] = shadow_perm[other[7:0]];
            shadow_perm[other[7:0]]      = hold;
            shadow_pos    = shadow_pos + 9'd1;
            res.byte_used = 1'b1;
            if (9'd256 - shadow_pos <= 9'd1) shadow_done = 1'b1;
          end
        end
      end
      MODE_READ: begin
        res.entry_value = shadow_perm[it.index];
      end
      default: begin
      end
    endcase
    res.placed_count = shadow_pos[7:0];
    res.shuffle_done = shadow_done;
    return res;
  endfunction

  task automatic add_item(input logic [1:0] mode, input int entropy, input int index);
    shuffle_item_t it;
    it.mode    = mode;
    it.entropy = entropy[7:0];
    it.index   = index[7:0];
    shuffle_items.push_back(it);
  endtask

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  // driver: next beat offered at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_accept) begin
        if (shuffle_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_mode         <= shuffle_items[0].mode;
          in_entropy_byte <= shuffle_items[0].entropy;
          in_read_index   <= shuffle_items[0].index;
          in_valid        <= 1'b1;
          void'(shuffle_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: results checked and new predictions made at the rising edge
  always @(posedge clk) begin
    shuffle_item_t   it;
    shuffle_status_t exp_st;
    in_accept <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (predicted_status_q.size() == 0) begin
          $error("result beat with no item outstanding");
          mismatches++;
        end else begin
          exp_st = predicted_status_q.pop_front();
          check_field("entry_value", exp_st.entry_value, out_entry_value);
          check_field("placed_count", exp_st.placed_count, out_placed_count);
          check_field("shuffle_done", exp_st.shuffle_done, out_shuffle_done);
          check_field("byte_used", exp_st.byte_used, out_byte_used);
        end
      end
      if (in_valid && in_ready) begin
        it.mode    = in_mode;
        it.entropy = in_entropy_byte;
        it.index   = in_read_index;
        predicted_status_q.push_back(apply_shuffle_item(it));
        accepted_items <= accepted_items + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int campaign;
    int n_bytes;
    bit full_run;
    restart_shadow();

    // directed: reads at both ends, unused mode, first swaps, rejection
    add_item(MODE_READ, 0, 0);
    add_item(MODE_READ, 8'hff, 255);
    add_item(MODE_UNUSED, 8'hff, 8'hff);
    add_item(MODE_ENTROPY, 0, 0);          // self swap at slot 0
    add_item(MODE_ENTROPY, 255, 0);        // limit is 255 here, so dropped
    add_item(MODE_ENTROPY, 254, 0);        // swaps slot 1 with slot 255
    add_item(MODE_READ, 0, 1);
    add_item(MODE_READ, 0, 255);
    add_item(MODE_ENTROPY, 253, 0);        // just under the limit of 254
    add_item(MODE_ENTROPY, 253, 0);        // exactly at the limit of 253
    add_item(MODE_ENTROPY, 128, 0);
    add_item(MODE_UNUSED, 0, 0);
    add_item(MODE_READ, 0, 2);
    add_item(MODE_RESTART, 8'hff, 8'hff);
    add_item(MODE_READ, 0, 1);
    add_item(MODE_READ, 0, 255);
    add_item(MODE_ENTROPY, 255, 0);        // full range, nothing dropped

    // random: full shuffles run past done, partial ones left half mixed
    campaign = 0;
    while (shuffle_items.size() < ITEM_GOAL) begin
      full_run = (campaign == 0) || (campaign == 3);
      if (full_run || $urandom_range(0, 99) < 85)
        add_item(MODE_RESTART, $urandom, $urandom);
      n_bytes = full_run ? FULL_BYTES : $urandom_range(5, 60);
      for (int k = 0; k < n_bytes; k++) begin
        // bytes up to 128 are never dropped, which keeps full runs short
        if (full_run && $urandom_range(0, 1) == 0)
          add_item(MODE_ENTROPY, $urandom_range(0, 128), $urandom);
        else
          add_item(MODE_ENTROPY, $urandom_range(0, 255), $urandom);
        if ($urandom_range(0, 99) < 10)
          add_item(MODE_READ, $urandom, $urandom_range(0, 255));
        if ($urandom_range(0, 99) < 2)
          add_item(MODE_UNUSED, $urandom, $urandom);
      end
      for (int k = $urandom_range(2, 12); k > 0; k--)
        add_item(MODE_READ, $urandom, $urandom_range(0, 255));
      campaign++;
    end
    total_items = shuffle_items.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (shuffle_items.size() != 0 || in_valid || predicted_status_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_byte_driven_permutation_shuffle passed");
    end else begin
      $display("tb_byte_driven_permutation_shuffle failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("tb_byte_driven_permutation_shuffle failed");
    $finish;
  end

endmodule
